// File: rtl/core/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants for the first-fit pool allocator: result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int unsigned STATUS_W = 3;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_NO_SPACE    = 3'd1;
    localparam t_status ST_NOT_FOUND   = 3'd2;
    localparam t_status ST_DOUBLE_FREE = 3'd3;
    localparam t_status ST_ZERO_SIZE   = 3'd4;

endpackage

`default_nettype wire

// File: rtl/core/first_fit_pool_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// Address-ordered segment table in one synchronous RAM; first-fit allocate
// with split, free with coalescing of touching free neighbors.
// ----------------------------------------------------------------------------
// Each scanned entry costs a RAM read and a check; a split or merge also moves
// table entries, each with one read and one write. One word in flight at a
// time; the single RAM port pair sets the rate. Reset and each pool_size write
// rebuild the table as one free segment in S_INIT.
`default_nettype none

module first_fit_pool_allocator #(
    parameter int unsigned MAX_SEGMENTS = 32,
    parameter int unsigned ADDR_BITS    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [16:0]              i_cfg_pool_size,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_action,
    input  wire logic [16:0]              i_request_size,
    input  wire logic [15:0]              i_free_offset,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [15:0]                   o_granted_offset,
    output ffpa_pkg::t_status             o_status
);
    import ffpa_pkg::*;

    localparam int unsigned LW = (ADDR_BITS + 1 > 17) ? ADDR_BITS + 1 : 17;
    localparam int unsigned SW = LW - 1;
    localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [LW-1:0] PMAX = LW'(1) << ADDR_BITS;
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_CK = 4'd3;
    localparam logic [3:0] S_SH_RD   = 4'd4;
    localparam logic [3:0] S_SH_WR   = 4'd5;
    localparam logic [3:0] S_SPLIT1  = 4'd6;
    localparam logic [3:0] S_SPLIT2  = 4'd7;
    localparam logic [3:0] S_PREV_RD = 4'd8;
    localparam logic [3:0] S_PREV_CK = 4'd9;
    localparam logic [3:0] S_NEXT_RD = 4'd10;
    localparam logic [3:0] S_NEXT_CK = 4'd11;
    localparam logic [3:0] S_FWR     = 4'd12;
    localparam logic [3:0] S_MV_RD   = 4'd13;
    localparam logic [3:0] S_MV_WR   = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [LW-1:0] len;
        logic          used;
    } t_seg;

    t_seg mem [MAX_SEGMENTS];
    t_seg rdata;

    logic [3:0]    r_state, n_state;
    logic [LW-1:0] r_pool, n_pool;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_base_idx, n_base_idx;
    logic [1:0]    r_rm, n_rm;
    logic          r_act, n_act;
    logic [LW-1:0] r_size, n_size;
    logic [SW-1:0] r_off, n_off;
    t_seg          r_cur, n_cur;
    t_seg          r_base, n_base;
    logic [LW-1:0] r_rest, n_rest;
    logic [SW-1:0] r_grant, n_grant;
    t_status       r_st, n_st;
    logic          r_ov, n_ov;
    logic [15:0]   r_og, n_og;
    t_status       r_os, n_os;

    logic [IW-1:0] raddr, waddr;
    logic          we;
    t_seg          wdata;
    logic [LW:0]   sum_rd, sum_base;
    logic [LW-1:0] cfg_ext;

    always_ff @(posedge i_clk) begin
        rdata <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign sum_rd   = (LW+1)'(rdata.start) + (LW+1)'(rdata.len);
    assign sum_base = (LW+1)'(r_base.start) + (LW+1)'(r_base.len);
    assign cfg_ext  = LW'(i_cfg_pool_size);

    assign o_cfg_ready      = (r_state == S_IDLE);
    assign o_in_ready       = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid      = r_ov;
    assign o_granted_offset = r_og;
    assign o_status         = r_os;

    always_comb begin
        n_state    = r_state;
        n_pool     = r_pool;
        n_count    = r_count;
        n_idx      = r_idx;
        n_ptr      = r_ptr;
        n_base_idx = r_base_idx;
        n_rm       = r_rm;
        n_act      = r_act;
        n_size     = r_size;
        n_off      = r_off;
        n_cur      = r_cur;
        n_base     = r_base;
        n_rest     = r_rest;
        n_grant    = r_grant;
        n_st       = r_st;
        n_ov       = r_ov && !i_out_ready;
        n_og       = r_og;
        n_os       = r_os;
        raddr      = r_idx[IW-1:0];
        waddr      = r_idx[IW-1:0];
        we         = 1'b0;
        wdata      = '0;

        unique case (r_state)
            S_INIT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = '{start: '0, len: r_pool, used: 1'b0};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (cfg_ext == '0) begin
                        n_pool = LW'(1);
                    end else if (cfg_ext > PMAX) begin
                        n_pool = PMAX;
                    end else begin
                        n_pool = cfg_ext;
                    end
                    n_state = S_INIT;
                end else if (i_in_valid) begin
                    n_act   = i_action;
                    n_size  = LW'(i_request_size);
                    n_off   = SW'(i_free_offset);
                    n_idx   = '0;
                    n_grant = '0;
                    if (!i_action && i_request_size == '0) begin
                        n_st    = ST_ZERO_SIZE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    n_st    = r_act ? ST_NOT_FOUND : ST_NO_SPACE;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                n_state = S_SCAN_RD;
                n_idx   = r_idx + CW'(1);
                if (!r_act) begin
                    if (!rdata.used && rdata.len >= r_size) begin
                        n_idx   = r_idx;
                        n_cur   = rdata;
                        n_grant = rdata.start;
                        n_rest  = rdata.len - r_size;
                        n_st    = ST_OK;
                        if (rdata.len != r_size && r_count < CMAX) begin
                            n_ptr   = r_count;
                            n_state = (r_count > r_idx + CW'(1)) ? S_SH_RD : S_SPLIT1;
                        end else begin
                            we      = 1'b1;
                            wdata   = '{start: rdata.start, len: rdata.len, used: 1'b1};
                            n_state = S_OUT;
                        end
                    end
                end else if (rdata.start == r_off) begin
                    n_idx = r_idx;
                    if (!rdata.used) begin
                        n_st    = ST_DOUBLE_FREE;
                        n_state = S_OUT;
                    end else begin
                        n_st       = ST_OK;
                        n_cur      = '{start: rdata.start, len: rdata.len, used: 1'b0};
                        n_base     = '{start: rdata.start, len: rdata.len, used: 1'b0};
                        n_base_idx = r_idx;
                        n_rm       = 2'd0;
                        if (r_idx != '0) begin
                            n_state = S_PREV_RD;
                        end else if (r_idx + CW'(1) < r_count) begin
                            n_state = S_NEXT_RD;
                        end else begin
                            n_state = S_FWR;
                        end
                    end
                end
            end
            S_SH_RD: begin
                raddr   = r_ptr[IW-1:0] - IW'(1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                we      = 1'b1;
                waddr   = r_ptr[IW-1:0];
                wdata   = rdata;
                n_ptr   = r_ptr - CW'(1);
                n_state = (r_ptr - CW'(1) > r_idx + CW'(1)) ? S_SH_RD : S_SPLIT1;
            end
            S_SPLIT1: begin
                we      = 1'b1;
                wdata   = '{start: r_cur.start, len: r_size, used: 1'b1};
                n_state = S_SPLIT2;
            end
            S_SPLIT2: begin
                we      = 1'b1;
                waddr   = r_idx[IW-1:0] + IW'(1);
                wdata   = '{start: r_cur.start + SW'(r_size), len: r_rest, used: 1'b0};
                n_count = r_count + CW'(1);
                n_state = S_OUT;
            end
            S_PREV_RD: begin
                raddr   = r_idx[IW-1:0] - IW'(1);
                n_state = S_PREV_CK;
            end
            S_PREV_CK: begin
                if (!rdata.used && sum_rd == (LW+1)'(r_cur.start)) begin
                    n_base     = '{start: rdata.start, len: rdata.len + r_cur.len,
                                   used: 1'b0};
                    n_base_idx = r_idx - CW'(1);
                    n_rm       = 2'd1;
                end
                n_ptr   = r_idx + CW'(1);
                n_state = (r_idx + CW'(1) < r_count) ? S_NEXT_RD : S_FWR;
            end
            S_NEXT_RD: begin
                raddr   = r_idx[IW-1:0] + IW'(1);
                n_state = S_NEXT_CK;
            end
            S_NEXT_CK: begin
                if (!rdata.used && sum_base == (LW+1)'(rdata.start)) begin
                    n_base.len = r_base.len + rdata.len;
                    n_rm       = r_rm + 2'd1;
                    n_ptr      = r_idx + CW'(2);
                end else begin
                    n_ptr      = r_idx + CW'(1);
                end
                n_state = S_FWR;
            end
            S_FWR: begin
                we    = 1'b1;
                waddr = r_base_idx[IW-1:0];
                wdata = r_base;
                if (r_rm == 2'd0) begin
                    n_state = S_OUT;
                end else if (r_ptr < r_count) begin
                    n_state = S_MV_RD;
                end else begin
                    n_count = r_count - CW'(r_rm);
                    n_state = S_OUT;
                end
            end
            S_MV_RD: begin
                raddr   = r_ptr[IW-1:0];
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                we    = 1'b1;
                waddr = r_ptr[IW-1:0] - IW'(r_rm);
                wdata = rdata;
                n_ptr = r_ptr + CW'(1);
                if (r_ptr + CW'(1) < r_count) begin
                    n_state = S_MV_RD;
                end else begin
                    n_count = r_count - CW'(r_rm);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_og    = r_grant[15:0];
                    n_os    = r_st;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_pool  <= (LW'(65536) > PMAX) ? PMAX : LW'(65536);
            r_count <= CW'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_base_idx <= n_base_idx;
        r_rm       <= n_rm;
        r_act      <= n_act;
        r_size     <= n_size;
        r_off      <= n_off;
        r_cur      <= n_cur;
        r_base     <= n_base;
        r_rest     <= n_rest;
        r_grant    <= n_grant;
        r_st       <= n_st;
        r_og       <= n_og;
        r_os       <= n_os;
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator testbench
// Drives allocate and free words with random idling on both sides, keeps its
// own segment table to predict each response, and checks responses in order.
// Pool size is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class pool_scoreboard;
    localparam int NSEG = 32;
    int unsigned pool_bytes;
    int unsigned seg_base[NSEG];
    int unsigned seg_len[NSEG];
    bit          seg_busy[NSEG];
    int unsigned nseg;
    logic [15:0]        exp_offset[$];
    ffpa_pkg::t_status  exp_status[$];
    int unsigned errors;
    int unsigned live[$];

    function void set_pool(logic [16:0] v);
        int unsigned p;
        p = 32'(v);
        if (p == 0) p = 1;
        if (p > 32'h10000) p = 32'h10000;
        pool_bytes = p;
        for (int k = 0; k < NSEG; k++) begin
            seg_base[k] = 0; seg_len[k] = 0; seg_busy[k] = 0;
        end
        seg_len[0] = p;
        nseg = 1;
        live.delete();
    endfunction

    function void drop_entry(int unsigned k);
        for (int unsigned j = k; j + 1 < nseg; j++) begin
            seg_base[j] = seg_base[j+1]; seg_len[j] = seg_len[j+1];
            seg_busy[j] = seg_busy[j+1];
        end
        nseg--;
        seg_base[nseg] = 0; seg_len[nseg] = 0; seg_busy[nseg] = 0;
    endfunction

    function void note_request(logic act, logic [16:0] sz, logic [15:0] off);
        int unsigned i;
        ffpa_pkg::t_status st;
        logic [15:0] g;
        g = '0;
        if (act == 1'b0) begin
            if (sz == 0) st = ffpa_pkg::ST_ZERO_SIZE;
            else begin
                st = ffpa_pkg::ST_NO_SPACE;
                for (i = 0; i < nseg; i++) begin
                    if (!seg_busy[i] && seg_len[i] >= 32'(sz)) break;
                end
                if (i < nseg) begin
                    st = ffpa_pkg::ST_OK;
                    seg_busy[i] = 1;
                    g = seg_base[i][15:0];
                    live.push_back(seg_base[i]);
                    if (seg_len[i] > 32'(sz) && nseg < NSEG) begin
                        for (int unsigned j = nseg; j > i + 1; j--) begin
                            seg_base[j] = seg_base[j-1]; seg_len[j] = seg_len[j-1];
                            seg_busy[j] = seg_busy[j-1];
                        end
                        seg_base[i+1] = seg_base[i] + 32'(sz);
                        seg_len[i+1] = seg_len[i] - 32'(sz);
                        seg_busy[i+1] = 0;
                        seg_len[i] = 32'(sz);
                        nseg++;
                    end
                end
            end
        end else begin
            for (i = 0; i < nseg; i++) if (seg_base[i] == 32'(off)) break;
            if (i >= nseg) st = ffpa_pkg::ST_NOT_FOUND;
            else if (!seg_busy[i]) st = ffpa_pkg::ST_DOUBLE_FREE;
            else begin
                st = ffpa_pkg::ST_OK;
                seg_busy[i] = 0;
                foreach (live[k]) if (live[k] == 32'(off)) begin live.delete(k); break; end
                if (i > 0 && !seg_busy[i-1] && seg_base[i-1] + seg_len[i-1] == seg_base[i])
                begin
                    seg_len[i-1] += seg_len[i];
                    drop_entry(i);
                    i--;
                end
                if (i + 1 < nseg && !seg_busy[i+1] && seg_base[i] + seg_len[i] == seg_base[i+1])
                begin
                    seg_len[i] += seg_len[i+1];
                    drop_entry(i + 1);
                end
            end
        end
        exp_offset.push_back(g);
        exp_status.push_back(st);
    endfunction

    function void check_response(logic [15:0] off, ffpa_pkg::t_status st);
        if (exp_status.size() == 0) begin
            $error("unexpected response: granted_offset %0d status %0d", off, st);
            errors++;
            return;
        end
        if (off !== exp_offset[0]) begin
            $error("granted_offset: expected %0d, got %0d", exp_offset[0], off);
            errors++;
        end
        if (st !== exp_status[0]) begin
            $error("status: expected %0d, got %0d", exp_status[0], st);
            errors++;
        end
        void'(exp_offset.pop_front());
        void'(exp_status.pop_front());
    endfunction
endclass

module testbench;
    import ffpa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_pool_size;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [16:0] i_request_size;
    logic [15:0] i_free_offset;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_granted_offset;
    t_status     o_status;

    pool_scoreboard pool_sb;
    bit          calm;

    first_fit_pool_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_pool_size(i_cfg_pool_size),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_request_size(i_request_size),
        .i_free_offset(i_free_offset),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_granted_offset(o_granted_offset), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("first_fit_pool_allocator test failed");
        $finish;
    end

    // response side: random stall bursts, checks on each accepted word
    initial begin
        int unsigned n;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) pool_sb.check_response(o_granted_offset, o_status);
        end
    end

    task automatic send_word(logic act, logic [16:0] sz, logic [15:0] off);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_request_size <= sz;
        i_free_offset  <= off;
        do @(posedge i_clk); while (!o_in_ready);
        pool_sb.note_request(act, sz, off);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pool_sb.exp_status.size() != 0) @(posedge i_clk);
        repeat (4 * 32 + 20) @(posedge i_clk);
    endtask

    task automatic write_pool(logic [16:0] v);
        drain();
        i_cfg_valid     <= 1'b1;
        i_cfg_pool_size <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_sb.set_pool(v);
        @(posedge i_clk);
    endtask

    task automatic random_word(int unsigned scale);
        int unsigned r;
        logic [16:0] sz;
        logic [15:0] off;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0: sz = 17'($urandom_range(1, 16));
                1: sz = 17'($urandom_range(1, scale));
                2: sz = 17'($urandom);
                default: sz = 17'($urandom_range(0, 2));
            endcase
            send_word(1'b0, sz, 16'($urandom));
        end else if (r < 88 && pool_sb.live.size() != 0) begin
            off = 16'(pool_sb.live[$urandom_range(0, pool_sb.live.size() - 1)]);
            send_word(1'b1, 17'($urandom), off);
        end else if (r < 94 && pool_sb.nseg > 1) begin
            off = 16'(pool_sb.seg_base[$urandom_range(0, pool_sb.nseg - 1)]);
            send_word(1'b1, 17'($urandom), off);
        end else begin
            send_word(1'b1, 17'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [16:0] sizes[6];
        pool_sb = new();
        pool_sb.set_pool(17'h10000);
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_pool_size = '0;
        i_in_valid      = 1'b0;
        i_action        = 1'b0;
        i_request_size  = '0;
        i_free_offset   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero size, too big, exact fit, split, frees with merges
        send_word(1'b0, 17'd0, 16'hffff);
        send_word(1'b0, 17'h10001, 16'd0);
        send_word(1'b0, 17'h1ffff, 16'd0);
        send_word(1'b0, 17'd100, 16'd0);
        send_word(1'b0, 17'd200, 16'd0);
        send_word(1'b0, 17'd300, 16'd0);
        send_word(1'b1, 17'h1ffff, 16'd5);
        send_word(1'b1, 17'd0, 16'd100);
        send_word(1'b1, 17'd0, 16'd100);
        send_word(1'b1, 17'd0, 16'd0);
        send_word(1'b1, 17'd0, 16'd300);
        send_word(1'b1, 17'd0, 16'hffff);
        send_word(1'b0, 17'h10000, 16'd0);
        send_word(1'b1, 17'd0, 16'd0);
        // table full: many one-byte grants, then a whole-segment grant
        for (int k = 0; k < 33; k++) send_word(1'b0, 17'd1, 16'd0);
        write_pool(17'd0);
        send_word(1'b0, 17'd2, 16'd0);
        send_word(1'b0, 17'd1, 16'd0);
        send_word(1'b1, 17'd0, 16'd0);
        write_pool(17'h1ffff);
        send_word(1'b0, 17'h10000, 16'd0);
        send_word(1'b1, 17'd0, 16'd0);

        sizes = '{17'd1, 17'd64, 17'd700, 17'd4096, 17'h10000, 17'h1ffff};
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(sizes[ph]);
            if (ph == 5) calm = 1'b1;
            for (int k = 0; k < 250; k++) random_word(ph < 2 ? 8 : sizes[ph] / 8 + 1);
        end

        drain();
        if (pool_sb.errors == 0) begin
            $display("first_fit_pool_allocator test passed");
        end else begin
            $display("first_fit_pool_allocator test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
